@@ hdl/lsht_pkg.sv @@
// Shared types, constants and helpers for the line segment hit test block.
// No dependencies; used by lsht_datapath and line_segment_hit_test.
`default_nettype none
package lsht_pkg;

  localparam int COORD_W = 16;
  localparam int REG_W = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int DIFF_W = COORD_W + 1;   // difference of two coordinates
  localparam int SUM_W = COORD_W + 3;    // a + b - 2c
  localparam int PROD_W = 2 * DIFF_W;    // product of two differences
  localparam int WIDE_W = PROD_W + 1;    // difference of two products
  localparam int TOL_W = REG_W + 1;      // margin plus thickness
  localparam int LIM_W = TOL_W + COORD_W;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_HIT_MARGIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_THICKNESS = 2'd1;

  localparam logic [REG_W-1:0] RESET_HIT_MARGIN = 8'd10;
  localparam logic [REG_W-1:0] RESET_LINE_THICKNESS = 8'd1;

  // Stage advance strobes from the pipeline control to the datapath.
  typedef struct packed {
    logic s1;
    logic s2;
  } adv_t;

  function automatic logic [WIDE_W-1:0] mag(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-1:0] r;
    r = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/lsht_datapath.sv @@
// Two payload stages of the hit test: coordinate differences, then products.
// Depends on lsht_pkg; the result register lives in line_segment_hit_test.
`default_nettype none
module lsht_datapath (
  input  wire logic                              clk,
  input  wire lsht_pkg::adv_t                    adv,
  input  wire logic signed [lsht_pkg::COORD_W-1:0] start_x,
  input  wire logic signed [lsht_pkg::COORD_W-1:0] start_y,
  input  wire logic signed [lsht_pkg::COORD_W-1:0] end_x,
  input  wire logic signed [lsht_pkg::COORD_W-1:0] end_y,
  input  wire logic                              end_present,
  input  wire logic signed [lsht_pkg::COORD_W-1:0] test_x,
  input  wire logic signed [lsht_pkg::COORD_W-1:0] test_y,
  input  wire logic [lsht_pkg::REG_W-1:0]        hit_margin,
  input  wire logic [lsht_pkg::REG_W-1:0]        line_thickness,
  output logic                                   hit_next
);

  localparam int DW = lsht_pkg::DIFF_W;
  localparam int SW = lsht_pkg::SUM_W;
  localparam int PW = lsht_pkg::PROD_W;
  localparam int WW = lsht_pkg::WIDE_W;

  // Stage 1: differences and band flags.
  logic signed [SW-1:0] sum_x, sum_y;
  logic                 between_y, between_x;
  logic signed [DW-1:0] dx, dy, ex, ey;
  logic                 present1;

  logic signed [SW-1:0] x1s, x2s, pxs, y1s, y2s, pys;

  always_comb begin
    x1s = SW'(start_x);
    x2s = SW'(end_x);
    pxs = SW'(test_x);
    y1s = SW'(start_y);
    y2s = SW'(end_y);
    pys = SW'(test_y);
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      sum_x <= x1s + x2s - (pxs <<< 1);
      sum_y <= y1s + y2s - (pys <<< 1);
      between_y <= (test_y > start_y && test_y < end_y) ||
                   (test_y < start_y && test_y > end_y);
      between_x <= (test_x > start_x && test_x < end_x) ||
                   (test_x < start_x && test_x > end_x);
      dx <= DW'(end_x) - DW'(start_x);
      dy <= DW'(end_y) - DW'(start_y);
      ex <= DW'(test_x) - DW'(start_x);
      ey <= DW'(test_y) - DW'(start_y);
      present1 <= end_present;
    end
  end

  // Stage 2: band decisions and the products of the angled test.
  logic                              vband, hband;
  logic signed [PW-1:0]              prod_a, prod_b, box_l, box_r;
  logic [lsht_pkg::LIM_W-1:0]        limit;
  logic                              box_en;

  logic [WW-1:0]                     sum_x_mag, sum_y_mag, dx_mag;
  logic [lsht_pkg::TOL_W-1:0]        tol;

  always_comb begin
    sum_x_mag = lsht_pkg::mag(WW'(sum_x));
    sum_y_mag = lsht_pkg::mag(WW'(sum_y));
    dx_mag = lsht_pkg::mag(WW'(dx));
    tol = lsht_pkg::TOL_W'(hit_margin) + lsht_pkg::TOL_W'(line_thickness);
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      vband <= present1 && between_y && (sum_x_mag < WW'(hit_margin));
      hband <= present1 && between_x && (sum_y_mag < WW'(hit_margin));
      prod_a <= ey * dx;
      prod_b <= dy * ex;
      box_l <= ey * ex;
      box_r <= dy * dx;
      limit <= tol * dx_mag[lsht_pkg::COORD_W-1:0];
      // drop the angled case for an absent end point
      box_en <= present1;
    end
  end

  // Final decision feeds the result register.
  logic [WW-1:0] dev_mag, box_l_mag, box_r_mag;

  always_comb begin
    dev_mag = lsht_pkg::mag(WW'(prod_a) - WW'(prod_b));
    box_l_mag = lsht_pkg::mag(WW'(box_l));
    box_r_mag = lsht_pkg::mag(WW'(box_r));
    hit_next = vband || hband ||
               (box_en && (box_l_mag < box_r_mag) && (dev_mag <= WW'(limit)));
  end

endmodule
`default_nettype wire

@@ hdl/line_segment_hit_test.sv @@
// Line segment hit test: top level with pipeline control and config registers.
// Depends on lsht_pkg and lsht_datapath.
// One item per cycle while the result side is not stalled.
// Throughput is set by the three-register pipeline: difference stage, product
// stage, result register; the input stalls only when all three are full and
// the result is stalled. Reset clears valid bits, sets hit_margin 10, thickness 1.
`default_nettype none
module line_segment_hit_test (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // input channel
  input  wire logic                                 valid,
  output logic                                      stall,
  input  wire logic signed [lsht_pkg::COORD_W-1:0]  start_x,
  input  wire logic signed [lsht_pkg::COORD_W-1:0]  start_y,
  input  wire logic signed [lsht_pkg::COORD_W-1:0]  end_x,
  input  wire logic signed [lsht_pkg::COORD_W-1:0]  end_y,
  input  wire logic                                 end_present,
  input  wire logic signed [lsht_pkg::COORD_W-1:0]  test_x,
  input  wire logic signed [lsht_pkg::COORD_W-1:0]  test_y,
  // result channel
  output logic                                      result_valid,
  input  wire logic                                 result_stall,
  output logic                                      hit,
  // configuration port
  input  wire logic                                 cfg_write,
  input  wire logic [lsht_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [lsht_pkg::REG_W-1:0]           cfg_data
);

  logic [lsht_pkg::REG_W-1:0] hit_margin;
  logic [lsht_pkg::REG_W-1:0] line_thickness;

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_margin <= lsht_pkg::RESET_HIT_MARGIN;
      line_thickness <= lsht_pkg::RESET_LINE_THICKNESS;
    end else if (cfg_write) begin
      case (cfg_index)
        lsht_pkg::REG_HIT_MARGIN:     hit_margin <= cfg_data;
        lsht_pkg::REG_LINE_THICKNESS: line_thickness <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline occupancy. A stage advances when it is empty or the stage
  // after it moves, so bubbles collapse and a full pipe takes one transfer
  // per cycle while the result side keeps up.
  logic v1, v2;
  logic ready1, ready2, ready3;
  lsht_pkg::adv_t adv;

  always_comb begin
    ready3 = !result_valid || !result_stall;
    ready2 = !v2 || ready3;
    ready1 = !v1 || ready2;
    stall = !ready1;
    adv.s1 = ready1;
    adv.s2 = ready2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        result_valid <= v2;
      end
    end
  end

  logic hit_next;

  lsht_datapath u_datapath (
    .clk            (clk),
    .adv            (adv),
    .start_x        (start_x),
    .start_y        (start_y),
    .end_x          (end_x),
    .end_y          (end_y),
    .end_present    (end_present),
    .test_x         (test_x),
    .test_y         (test_y),
    .hit_margin     (hit_margin),
    .line_thickness (line_thickness),
    .hit_next       (hit_next)
  );

  // Result register: hold while the consumer stalls.
  always_ff @(posedge clk) begin
    if (ready3) begin
      hit <= hit_next;
    end
  end

  // A full pipe under a result stall must stall the input.
  assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && result_valid && result_stall) |-> stall)
    else $error("input taken while pipeline full and blocked");

  // A result leaves only through a transfer.
  assert property (@(posedge clk) disable iff (rst)
    $fell(result_valid) |-> $past(!result_stall))
    else $error("result dropped without transfer");

  // A margin write lands in the register.
  assert property (@(posedge clk) disable iff (rst)
    (cfg_write && cfg_index == lsht_pkg::REG_HIT_MARGIN) |=>
      (hit_margin == $past(cfg_data)))
    else $error("hit_margin write lost");

  // An empty pipe never stalls the input.
  assert property (@(posedge clk) disable iff (rst)
    (!v1) |-> !stall)
    else $error("stall with empty input stage");

endmodule
`default_nettype wire

@@ sim/line_segment_hit_test_tb.sv @@
// Self-checking testbench for line_segment_hit_test: directed table, then random
// segment queries under several register settings and handshake idling patterns.
// Depends on lsht_pkg and the line_segment_hit_test RTL; reads no files.
`default_nettype none
module line_segment_hit_test_tb;

  // Drain allowance for settle, which adds a small margin on drain.
  localparam int LATENCY_CYCLES = 2;
  localparam int RANDOM_PER_PHASE = 120;
  localparam int NUM_PHASES = 7;
  localparam int MAX_REPORTS = 10;

  // Indexes with no register behind them; writes there must change nothing.
  localparam logic [lsht_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_2 = 2'd2;
  localparam logic [lsht_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_3 = 2'd3;

  typedef enum {CHECK_PREDICT, EXPECT_MISS, EXPECT_HIT} row_check_t;

  typedef struct {
    logic signed [lsht_pkg::COORD_W-1:0] sx;
    logic signed [lsht_pkg::COORD_W-1:0] sy;
    logic signed [lsht_pkg::COORD_W-1:0] ex;
    logic signed [lsht_pkg::COORD_W-1:0] ey;
    bit                                  present;
    logic signed [lsht_pkg::COORD_W-1:0] tx;
    logic signed [lsht_pkg::COORD_W-1:0] ty;
  } segment_query_t;

  typedef struct {
    segment_query_t q;
    row_check_t     kind;
  } directed_row_t;

  typedef struct {
    int seq;
    bit hit;
  } pending_hit_t;

  logic                                 clk = 1'b0;
  logic                                 rst;
  logic                                 valid;
  logic                                 stall;
  logic signed [lsht_pkg::COORD_W-1:0]  start_x;
  logic signed [lsht_pkg::COORD_W-1:0]  start_y;
  logic signed [lsht_pkg::COORD_W-1:0]  end_x;
  logic signed [lsht_pkg::COORD_W-1:0]  end_y;
  logic                                 end_present;
  logic signed [lsht_pkg::COORD_W-1:0]  test_x;
  logic signed [lsht_pkg::COORD_W-1:0]  test_y;
  logic                                 result_valid;
  logic                                 result_stall = 1'b0;
  logic                                 hit;
  logic                                 cfg_write;
  logic [lsht_pkg::CFG_INDEX_W-1:0]     cfg_index;
  logic [lsht_pkg::REG_W-1:0]           cfg_data;

  // Mirror of the two tolerance registers, as loaded by reset and by writes.
  logic [lsht_pkg::REG_W-1:0] margin_q = lsht_pkg::RESET_HIT_MARGIN;
  logic [lsht_pkg::REG_W-1:0] thick_q = lsht_pkg::RESET_LINE_THICKNESS;

  pending_hit_t  pending_hits[$];
  directed_row_t directed_rows[$];
  int            transfer_seq = 0;
  int            mismatch_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;

  line_segment_hit_test DUT (
    .clk          (clk),
    .rst          (rst),
    .valid        (valid),
    .stall        (stall),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .end_present  (end_present),
    .test_x       (test_x),
    .test_y       (test_y),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .hit          (hit),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Hit predictor. All products fit easily in 64 bits, so no wrap to model.
  // --------------------------------------------------------------------------
  function automatic longint mag64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit lies_strictly_between(input longint v, input longint a,
                                               input longint b);
    return (v > a && v < b) || (v < a && v > b);
  endfunction

  function automatic bit segment_hit(input segment_query_t q,
                                     input logic [lsht_pkg::REG_W-1:0] margin,
                                     input logic [lsht_pkg::REG_W-1:0] thick);
    longint x1, y1, x2, y2, px, py, m, k, dx, dy, dev;
    x1 = longint'(q.sx);
    y1 = longint'(q.sy);
    x2 = longint'(q.ex);
    y2 = longint'(q.ey);
    px = longint'(q.tx);
    py = longint'(q.ty);
    m = longint'(margin);
    k = m + longint'(thick);
    // No end point means no segment to hit.
    if (!q.present) return 1'b0;
    // Vertical band: 2*x near the x sum, y strictly between the endpoint ys.
    if (mag64(x1 + x2 - 2 * px) < m && lies_strictly_between(py, y1, y2)) return 1'b1;
    // Horizontal band: same with the axes swapped.
    if (mag64(y1 + y2 - 2 * py) < m && lies_strictly_between(px, x1, x2)) return 1'b1;
    // Angled band, gated by the distance-product box test; a vertical segment
    // zeroes the right-hand product and never gets here.
    if (mag64((y1 - py) * (x1 - px)) < mag64((y1 - y2) * (x1 - x2))) begin
      dx = x2 - x1;
      dy = y2 - y1;
      dev = (py - y1) * dx - dy * (px - x1);
      return mag64(dev) <= k * mag64(dx);
    end
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Random query shaping: mostly points scattered close to the segment so all
  // three bands are exercised near their edges, some around the endpoints,
  // and a share of fully random words so every input bit toggles.
  // --------------------------------------------------------------------------
  function automatic longint pick(input longint lo, input longint hi);
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  function automatic longint clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic segment_query_t random_query();
    segment_query_t q;
    int             mode;
    longint         span, cx, cy, x1, y1, x2, y2, t, j, px, py;
    mode = $urandom_range(99);
    if (mode >= 85) begin
      q.sx = 16'($urandom());
      q.sy = 16'($urandom());
      q.ex = 16'($urandom());
      q.ey = 16'($urandom());
      q.tx = 16'($urandom());
      q.ty = 16'($urandom());
      q.present = 1'($urandom_range(1));
      return q;
    end
    // Mostly short segments; now and then one spanning the whole plane.
    span = ($urandom_range(7) == 0) ? 65535 : (longint'(1) << $urandom_range(10, 2));
    cx = pick(-32768, 32767);
    cy = pick(-32768, 32767);
    x1 = clamp16(cx + pick(-span, span));
    y1 = clamp16(cy + pick(-span, span));
    x2 = clamp16(cx + pick(-span, span));
    y2 = clamp16(cy + pick(-span, span));
    if (mode < 10) x2 = x1;
    else if (mode < 20) y2 = y1;
    j = longint'(margin_q) + longint'(thick_q) + 4;
    if (mode < 70) begin
      // Point along the segment, slightly past both ends, then jittered.
      t = pick(-64, 1088);
      px = x1 + ((x2 - x1) * t) / 1024 + pick(-j, j);
      py = y1 + ((y2 - y1) * t) / 1024 + pick(-j, j);
    end else if ($urandom_range(1) == 0) begin
      px = x1 + pick(-j, j);
      py = y1 + pick(-j, j);
    end else begin
      px = x2 + pick(-j, j);
      py = y2 + pick(-j, j);
    end
    q.sx = 16'(clamp16(x1));
    q.sy = 16'(clamp16(y1));
    q.ex = 16'(clamp16(x2));
    q.ey = 16'(clamp16(y2));
    q.tx = 16'(clamp16(px));
    q.ty = 16'(clamp16(py));
    q.present = ($urandom_range(15) != 0);
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Drive at the falling edge, detect the transfer at the rising
  // edge, and record the expected hit only once the transfer has happened.
  // Valid stays high across back-to-back transfers with a single assignment.
  // --------------------------------------------------------------------------
  task automatic send_query(input segment_query_t q, input row_check_t kind);
    pending_hit_t p;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      valid <= 1'b0;
      @(negedge clk);
    end
    start_x <= q.sx;
    start_y <= q.sy;
    end_x <= q.ex;
    end_y <= q.ey;
    end_present <= q.present;
    test_x <= q.tx;
    test_y <= q.ty;
    valid <= 1'b1;
    // Hold the payload until the block takes it.
    @(posedge clk);
    while (stall) @(posedge clk);
    p.seq = transfer_seq;
    case (kind)
      EXPECT_HIT:  p.hit = 1'b1;
      EXPECT_MISS: p.hit = 1'b0;
      default:     p.hit = segment_hit(q, margin_q, thick_q);
    endcase
    pending_hits = {pending_hits, p};
    transfer_seq++;
  endtask

  // Drop valid, then wait for every outstanding result and the LATENCY_CYCLES drain allowance.
  task automatic settle();
    @(negedge clk);
    valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LATENCY_CYCLES + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lsht_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lsht_pkg::REG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == lsht_pkg::REG_HIT_MARGIN) margin_q = data;
    else if (idx == lsht_pkg::REG_LINE_THICKNESS) thick_q = data;
  endtask

  task automatic add_row(input int sx, input int sy, input int ex, input int ey,
                         input bit present, input int tx, input int ty,
                         input row_check_t kind);
    directed_row_t r;
    r.q.sx = 16'(sx);
    r.q.sy = 16'(sy);
    r.q.ex = 16'(ex);
    r.q.ey = 16'(ey);
    r.q.present = present;
    r.q.tx = 16'(tx);
    r.q.ty = 16'(ty);
    r.kind = kind;
    directed_rows = {directed_rows, r};
  endtask

  // --------------------------------------------------------------------------
  // Output side: receiver stalls at random, results checked in order.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : check_results
    pending_hit_t p;
    if (!rst && result_valid && !result_stall) begin
      if (pending_hits.size() == 0) begin
        report_mismatch($sformatf("result transfer with none pending, hit=%0b", hit));
      end else begin
        p = pending_hits.pop_front();
        if (hit !== p.hit)
          report_mismatch($sformatf("transfer %0d: hit expected %0b, got %0b",
                                    p.seq, p.hit, hit));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed table, then random phases across settings.
  // --------------------------------------------------------------------------
  initial begin : run_sequence
    segment_query_t q;
    int             phase;
    int             n;
    rst <= 1'b1;
    valid <= 1'b0;
    start_x <= '0;
    start_y <= '0;
    end_x <= '0;
    end_y <= '0;
    end_present <= 1'b0;
    test_x <= '0;
    test_y <= '0;
    cfg_write <= 1'b0;
    cfg_index <= lsht_pkg::REG_HIT_MARGIN;
    cfg_data <= '0;
    send_idle_pct = 14;
    recv_idle_pct = 82;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows run with the reset tolerances (margin 10, thickness 1).
    add_row(0, 0, 0, 0, 1'b1, 0, 0, EXPECT_MISS);            // degenerate segment
    add_row(0, 0, 0, 100, 1'b0, 0, 50, EXPECT_MISS);         // end point absent
    add_row(0, 0, 0, 100, 1'b1, 0, 50, EXPECT_HIT);          // vertical band center
    add_row(0, 0, 0, 100, 1'b1, 30, 50, EXPECT_MISS);        // vertical, off the band
    add_row(0, 0, 0, 100, 1'b1, 0, 100, EXPECT_MISS);        // on an endpoint, not between
    add_row(0, 0, 100, 0, 1'b1, 50, 2, EXPECT_HIT);          // horizontal band
    add_row(-32768, -32768, 32767, 32767, 1'b1, 0, 0, EXPECT_HIT);
    add_row(32767, -32768, -32768, 32767, 1'b1, 32767, 32767, CHECK_PREDICT);
    add_row(-32768, 32767, 32767, -32768, 1'b1, -32768, -32768, CHECK_PREDICT);
    add_row(-32768, -32768, -32768, -32768, 1'b1, 32767, 32767, CHECK_PREDICT);
    add_row(32767, 32767, -32768, 32767, 1'b1, 0, 32767, CHECK_PREDICT);
    add_row(0, 0, 100, 50, 1'b1, 40, 20, CHECK_PREDICT);     // angled, on the line
    add_row(0, 0, 100, 50, 1'b1, 40, 31, CHECK_PREDICT);     // angled, on the band edge
    add_row(0, 0, 100, 50, 1'b1, 40, 32, CHECK_PREDICT);     // angled, just outside
    add_row(0, 0, 100, 50, 1'b1, 150, 75, CHECK_PREDICT);    // beyond the box
    add_row(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b1, 0, 0, CHECK_PREDICT);
    add_row(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1'b1, 16'h5555, 16'hAAAA,
            CHECK_PREDICT);
    add_row(-5, 7, 9, -3, 1'b1, 2, 2, CHECK_PREDICT);
    foreach (directed_rows[i]) send_query(directed_rows[i].q, directed_rows[i].kind);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      case (phase)
        1: begin
          write_reg(lsht_pkg::REG_HIT_MARGIN, 8'd0);
          write_reg(lsht_pkg::REG_LINE_THICKNESS, 8'd0);
          write_reg(REG_UNMAPPED_2, 8'hFF);
        end
        2: begin
          write_reg(lsht_pkg::REG_HIT_MARGIN, 8'd255);
          write_reg(lsht_pkg::REG_LINE_THICKNESS, 8'd255);
        end
        3: begin
          write_reg(lsht_pkg::REG_HIT_MARGIN, 8'($urandom()));
          write_reg(lsht_pkg::REG_LINE_THICKNESS, 8'($urandom()));
          write_reg(REG_UNMAPPED_3, 8'h00);
        end
        4: begin
          write_reg(lsht_pkg::REG_HIT_MARGIN, 8'd1);
          write_reg(lsht_pkg::REG_LINE_THICKNESS, 8'd255);
        end
        5: begin
          write_reg(lsht_pkg::REG_HIT_MARGIN, 8'd255);
          write_reg(lsht_pkg::REG_LINE_THICKNESS, 8'd0);
        end
        6: begin
          write_reg(lsht_pkg::REG_HIT_MARGIN, 8'($urandom()));
          write_reg(lsht_pkg::REG_LINE_THICKNESS, 8'($urandom()));
        end
        default: ;
      endcase
      // Sender dense and receiver busy, then swapped, then full rate.
      if (phase < 2) begin
        send_idle_pct = 14;
        recv_idle_pct = 82;
      end else if (phase < 4) begin
        send_idle_pct = 82;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        q = random_query();
        send_query(q, CHECK_PREDICT);
        // Hold the sender once until the pipeline has fully drained.
        if (phase == 3 && n == RANDOM_PER_PHASE / 2) settle();
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

@@ line_segment_hit_test.f @@
hdl/lsht_pkg.sv
hdl/lsht_datapath.sv
hdl/line_segment_hit_test.sv
sim/line_segment_hit_test_tb.sv
